>>> hdl/vocd_pkg.sv
// Package: types, codes and constants shared by the VOC block stream decoder.
package vocd_pkg;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_SKIP,
        PH_TYPE,
        PH_LEN,
        PH_BODY,
        PH_DONE,
        PH_FAIL
    } phase_t;

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_DIV,
        SQ_POST
    } seq_t;

    typedef enum logic [1:0] {
        OP_PCM_RATE,
        OP_SILENCE,
        OP_EXT_RATE
    } div_op_t;

    localparam logic [3:0] ST_OK          = 4'd0;
    localparam logic [3:0] ST_BAD_HEADER  = 4'd1;
    localparam logic [3:0] ST_BAD_OFFSET  = 4'd2;
    localparam logic [3:0] ST_TRUNCATED   = 4'd3;
    localparam logic [3:0] ST_BAD_BLOCK   = 4'd4;
    localparam logic [3:0] ST_RATE_MISM   = 4'd5;
    localparam logic [3:0] ST_NO_RATE     = 4'd6;
    localparam logic [3:0] ST_UNSUPPORTED = 4'd7;
    localparam logic [3:0] ST_NO_AUDIO    = 4'd8;

    localparam logic [7:0] KIND_PCM      = 8'd1;
    localparam logic [7:0] KIND_CONT     = 8'd2;
    localparam logic [7:0] KIND_SILENCE  = 8'd3;
    localparam logic [7:0] KIND_LOOP     = 8'd6;
    localparam logic [7:0] KIND_EXT      = 8'd8;
    localparam logic [7:0] KIND_PCM_NEW  = 8'd9;

    localparam logic [7:0]  SIG_EOF      = 8'h1a;
    localparam logic [31:0] SIG_LEN      = 32'd19;
    localparam logic [31:0] HDR_LEN      = 32'd26;
    localparam logic [7:0]  SILENCE_VAL  = 8'h80;
    localparam logic [7:0]  RATE_BYTE_MAX = 8'hff;
    localparam logic [31:0] RATE_BASE    = 32'd1000000;
    localparam logic [31:0] EXT_BASE     = 32'd256000000;
    localparam logic [8:0]  TC_BASE      = 9'd256;
    localparam logic [16:0] EXT_TC_BASE  = 17'd65536;

    typedef struct packed {
        logic [7:0]  sample;
        logic [16:0] repeat_n;
        logic        is_final;
        logic [3:0]  status;
        logic [31:0] rate;
        logic        loop_seen;
    } res_t;

    function automatic logic [7:0] sig_byte(input logic [4:0] idx);
        logic [7:0] v;
        unique case (idx)
            5'd0:  v = 8'h43;
            5'd1:  v = 8'h72;
            5'd2:  v = 8'h65;
            5'd3:  v = 8'h61;
            5'd4:  v = 8'h74;
            5'd5:  v = 8'h69;
            5'd6:  v = 8'h76;
            5'd7:  v = 8'h65;
            5'd8:  v = 8'h20;
            5'd9:  v = 8'h56;
            5'd10: v = 8'h6f;
            5'd11: v = 8'h69;
            5'd12: v = 8'h63;
            5'd13: v = 8'h65;
            5'd14: v = 8'h20;
            5'd15: v = 8'h46;
            5'd16: v = 8'h69;
            5'd17: v = 8'h6c;
            5'd18: v = 8'h65;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

>>> hdl/voc_block_stream_decoder.sv
// VOC block stream decoder: header check, block walk, shared rate divider, result queue.
module voc_block_stream_decoder
    import vocd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_sample_value,
    output logic [16:0] m_repeat_count,
    output logic        m_is_final,
    output logic [3:0]  m_status,
    output logic [31:0] m_stream_rate,
    output logic        m_loop_seen
);

// Takes one file byte per cycle while the divider is idle and the queue has room.
// A byte that needs a rate computed (the codec byte of a type 1 block without a
// pending extended rate, the rate byte of a type 3 block) runs the shared 32-step
// restoring divider, then the post step applies the result; the block is not
// ready until that is done. The channel byte of a type 8 block runs the divider
// twice. Results pass through a two-entry queue; since one byte can add two
// results, a byte is taken only while the queue is empty or its one waiting
// result leaves in the same cycle. A nonzero status on the final result means
// the samples already sent must be discarded.

    phase_t      phase_reg,  phase_next;
    seq_t        seq_reg,    seq_next;
    div_op_t     op_reg,     op_next;
    logic [31:0] pos_reg,    pos_next;
    logic [15:0] offset_reg, offset_next;
    logic [7:0]  kind_reg,   kind_next;
    logic [23:0] remain_reg, remain_next;
    logic [23:0] index_reg,  index_next;
    logic [31:0] cur_reg,    cur_next;
    logic [31:0] ext_reg,    ext_next;
    logic [8:0]  ch_reg,     ch_next;
    logic [31:0] locked_reg, locked_next;
    logic        loop_reg,   loop_next;
    logic        any_reg,    any_next;
    logic [3:0]  err_reg,    err_next;
    logic        lastp_reg,  lastp_next;
    logic        pass2_reg,  pass2_next;
    logic [4:0]  cnt_reg,    cnt_next;
    logic [16:0] rem_reg,    rem_next;
    logic [31:0] quo_reg,    quo_next;
    logic [16:0] dvs_reg,    dvs_next;
    logic [1:0]  qcnt_reg,   qcnt_next;
    res_t        q0_reg,     q0_next;
    res_t        q1_reg,     q1_next;
    logic [7:0]  scratch [12];

    logic        acc, pop, room, scr_we, div_go, do_final, do_clear;
    logic [3:0]  scr_idx;
    logic [31:0] fp1, rate_v;
    logic [23:0] len_v;
    logic [3:0]  fin_status;
    logic [1:0]  push_n, c1;
    res_t        push0, push1, fin_res, samp_res, s0, s1;
    logic [17:0] trial;
    logic        ge;

    assign pop     = m_valid && m_ready;
    assign room    = (qcnt_reg == 2'd0) || ((qcnt_reg == 2'd1) && m_ready);
    assign s_ready = (seq_reg == SQ_IDLE) && room;
    assign acc     = s_valid && s_ready;

    assign m_valid        = (qcnt_reg != 2'd0);
    assign m_sample_value = q0_reg.sample;
    assign m_repeat_count = q0_reg.repeat_n;
    assign m_is_final     = q0_reg.is_final;
    assign m_status       = q0_reg.status;
    assign m_stream_rate  = q0_reg.rate;
    assign m_loop_seen    = q0_reg.loop_seen;

    assign trial = {rem_reg, quo_reg[31]};
    assign ge    = (trial >= {1'b0, dvs_reg});

    always_comb begin
        phase_next  = phase_reg;
        seq_next    = seq_reg;
        op_next     = op_reg;
        pos_next    = pos_reg;
        offset_next = offset_reg;
        kind_next   = kind_reg;
        remain_next = remain_reg;
        index_next  = index_reg;
        cur_next    = cur_reg;
        ext_next    = ext_reg;
        ch_next     = ch_reg;
        locked_next = locked_reg;
        loop_next   = loop_reg;
        any_next    = any_reg;
        err_next    = err_reg;
        lastp_next  = lastp_reg;
        pass2_next  = pass2_reg;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        dvs_next    = dvs_reg;
        scr_we      = 1'b0;
        scr_idx     = index_reg[3:0];
        div_go      = 1'b0;
        do_final    = 1'b0;
        do_clear    = 1'b0;
        push_n      = 2'd0;
        push0       = '0;
        push1       = '0;
        samp_res    = '0;
        rate_v      = '0;
        len_v       = '0;
        fp1         = (pos_reg != 32'hffff_ffff) ? pos_reg + 32'd1 : pos_reg;
        fin_status  = ST_OK;
        fin_res     = '0;

        if (acc) begin
            pos_next = fp1;
            unique case (phase_reg)
                PH_HEADER: begin
                    if (pos_reg < SIG_LEN) begin
                        if (s_data_byte != sig_byte(pos_reg[4:0])) begin
                            phase_next = PH_FAIL;
                            err_next   = ST_BAD_HEADER;
                        end
                    end else if (pos_reg == 32'd19) begin
                        if (s_data_byte != SIG_EOF) begin
                            phase_next = PH_FAIL;
                            err_next   = ST_BAD_HEADER;
                        end
                    end else if (pos_reg == 32'd20) begin
                        offset_next = {8'd0, s_data_byte};
                    end else if (pos_reg == 32'd21) begin
                        offset_next = {s_data_byte, offset_reg[7:0]};
                    end else if (pos_reg >= 32'd25) begin
                        if ({16'd0, offset_reg} < HDR_LEN) begin
                            phase_next = PH_FAIL;
                            err_next   = ST_BAD_OFFSET;
                        end else begin
                            phase_next = (fp1 >= {16'd0, offset_reg}) ? PH_TYPE : PH_SKIP;
                        end
                    end
                end
                PH_SKIP: begin
                    if (fp1 >= {16'd0, offset_reg}) phase_next = PH_TYPE;
                end
                PH_TYPE: begin
                    if (s_data_byte == 8'd0) begin
                        phase_next = PH_DONE;
                    end else begin
                        kind_next   = s_data_byte;
                        remain_next = '0;
                        index_next  = '0;
                        phase_next  = PH_LEN;
                    end
                end
                PH_LEN: begin
                    len_v = remain_reg;
                    unique case (index_reg[1:0])
                        2'd0:    len_v[7:0]   = len_v[7:0]   | s_data_byte;
                        2'd1:    len_v[15:8]  = len_v[15:8]  | s_data_byte;
                        2'd2:    len_v[23:16] = len_v[23:16] | s_data_byte;
                        default: len_v = len_v;
                    endcase
                    remain_next = len_v;
                    index_next  = index_reg + 24'd1;
                    if (index_reg >= 24'd2) begin
                        index_next = '0;
                        phase_next = (len_v != 24'd0) ? PH_BODY : PH_TYPE;
                        priority if (kind_reg == KIND_PCM && len_v < 24'd2) begin
                            phase_next = PH_FAIL;
                            err_next   = ST_BAD_BLOCK;
                        end else if (kind_reg == KIND_CONT && cur_reg == 32'd0) begin
                            phase_next = PH_FAIL;
                            err_next   = ST_NO_RATE;
                        end else if (kind_reg == KIND_SILENCE && len_v < 24'd3) begin
                            phase_next = PH_FAIL;
                            err_next   = ST_BAD_BLOCK;
                        end else if (kind_reg == KIND_LOOP) begin
                            loop_next = 1'b1;
                        end else if (kind_reg == KIND_EXT && len_v < 24'd4) begin
                            phase_next = PH_FAIL;
                            err_next   = ST_BAD_BLOCK;
                        end else if (kind_reg == KIND_PCM_NEW && len_v < 24'd12) begin
                            phase_next = PH_FAIL;
                            err_next   = ST_BAD_BLOCK;
                        end
                    end
                end
                PH_BODY: begin
                    scr_we = (index_reg < 24'd12);
                    samp_res = '{sample: s_data_byte, repeat_n: 17'd1, is_final: 1'b0,
                                 status: ST_OK, rate: locked_reg, loop_seen: loop_reg};
                    if (kind_reg == KIND_PCM) begin
                        if (index_reg == 24'd1) begin
                            if (s_data_byte != 8'd0 || ch_reg != 9'd1) begin
                                phase_next = PH_FAIL;
                                err_next   = ST_UNSUPPORTED;
                            end else if (ext_reg != 32'd0) begin
                                cur_next = ext_reg;
                                if (locked_reg == 32'd0) begin
                                    locked_next = ext_reg;
                                end else if (locked_reg != ext_reg) begin
                                    phase_next = PH_FAIL;
                                    err_next   = ST_RATE_MISM;
                                end
                                ext_next = '0;
                                ch_next  = 9'd1;
                            end else begin
                                div_go   = 1'b1;
                                op_next  = OP_PCM_RATE;
                                quo_next = RATE_BASE;
                                dvs_next = {8'd0, 9'(TC_BASE - {1'b0, scratch[0]})};
                            end
                        end else if (index_reg >= 24'd2) begin
                            push_n   = 2'd1;
                            push0    = samp_res;
                            any_next = 1'b1;
                        end
                    end else if (kind_reg == KIND_CONT) begin
                        push_n   = 2'd1;
                        push0    = samp_res;
                        any_next = 1'b1;
                    end else if (kind_reg == KIND_SILENCE) begin
                        if (index_reg == 24'd2) begin
                            if (s_data_byte == RATE_BYTE_MAX) begin
                                phase_next = PH_FAIL;
                                err_next   = ST_BAD_BLOCK;
                            end else begin
                                div_go   = 1'b1;
                                op_next  = OP_SILENCE;
                                quo_next = RATE_BASE;
                                dvs_next = {8'd0, 9'(TC_BASE - {1'b0, s_data_byte})};
                            end
                        end
                    end else if (kind_reg == KIND_EXT) begin
                        if (index_reg == 24'd2) begin
                            if (s_data_byte != 8'd0) begin
                                phase_next = PH_FAIL;
                                err_next   = ST_UNSUPPORTED;
                            end
                        end else if (index_reg == 24'd3) begin
                            ch_next  = {1'b0, s_data_byte} + 9'd1;
                            div_go   = 1'b1;
                            op_next  = OP_EXT_RATE;
                            quo_next = EXT_BASE;
                            dvs_next = 17'(EXT_TC_BASE - {1'b0, scratch[1], scratch[0]});
                        end
                    end else if (kind_reg == KIND_PCM_NEW) begin
                        if (index_reg == 24'd4) begin
                            if (s_data_byte != 8'd8) begin
                                phase_next = PH_FAIL;
                                err_next   = ST_UNSUPPORTED;
                            end
                        end else if (index_reg == 24'd5) begin
                            if (s_data_byte != 8'd1) begin
                                phase_next = PH_FAIL;
                                err_next   = ST_UNSUPPORTED;
                            end
                        end else if (index_reg == 24'd7) begin
                            rate_v = {scratch[3], scratch[2], scratch[1], scratch[0]};
                            if ({s_data_byte, scratch[6]} != 16'd0) begin
                                phase_next = PH_FAIL;
                                err_next   = ST_UNSUPPORTED;
                            end else begin
                                cur_next = rate_v;
                                if (locked_reg == 32'd0) begin
                                    locked_next = rate_v;
                                end else if (locked_reg != rate_v) begin
                                    phase_next = PH_FAIL;
                                    err_next   = ST_RATE_MISM;
                                end
                            end
                        end else if (index_reg >= 24'd12) begin
                            push_n   = 2'd1;
                            push0    = samp_res;
                            any_next = 1'b1;
                        end
                    end
                    if (phase_next == PH_BODY) begin
                        index_next  = index_reg + 24'd1;
                        remain_next = remain_reg - 24'd1;
                        if (remain_reg == 24'd1) phase_next = PH_TYPE;
                    end
                end
                PH_DONE, PH_FAIL: begin
                    phase_next = phase_reg;
                end
                default: phase_next = phase_reg;
            endcase
            if (div_go) begin
                seq_next   = SQ_DIV;
                lastp_next = s_last_byte;
                pass2_next = 1'b0;
                cnt_next   = '0;
                rem_next   = '0;
            end else begin
                do_final = s_last_byte;
            end
        end

        if (seq_reg == SQ_DIV) begin
            rem_next = ge ? 17'(trial - {1'b0, dvs_reg}) : trial[16:0];
            quo_next = {quo_reg[30:0], ge};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                if (op_reg == OP_EXT_RATE && !pass2_reg) begin
                    pass2_next = 1'b1;
                    rem_next   = '0;
                    dvs_next   = {8'd0, ch_reg};
                end else begin
                    seq_next = SQ_POST;
                end
            end
        end

        if (seq_reg == SQ_POST && room) begin
            seq_next = SQ_IDLE;
            do_final = lastp_reg;
            if (op_reg == OP_EXT_RATE) begin
                ext_next = quo_reg;
            end else begin
                cur_next = quo_reg;
                if (locked_reg == 32'd0) begin
                    locked_next = quo_reg;
                end else if (locked_reg != quo_reg) begin
                    phase_next = PH_FAIL;
                    err_next   = ST_RATE_MISM;
                end
                if (phase_next != PH_FAIL) begin
                    if (op_reg == OP_PCM_RATE) begin
                        ext_next = '0;
                        ch_next  = 9'd1;
                    end else begin
                        push_n   = 2'd1;
                        push0    = '{sample: SILENCE_VAL,
                                     repeat_n: {1'b0, scratch[1], scratch[0]} + 17'd1,
                                     is_final: 1'b0, status: ST_OK,
                                     rate: locked_next, loop_seen: loop_reg};
                        any_next = 1'b1;
                    end
                end
            end
        end

        if (do_final) begin
            unique case (phase_next)
                PH_FAIL:          fin_status = err_next;
                PH_HEADER:        fin_status = ST_BAD_HEADER;
                PH_SKIP:          fin_status = ST_BAD_OFFSET;
                PH_LEN, PH_BODY:  fin_status = ST_TRUNCATED;
                default: fin_status = (locked_next == 32'd0) ? ST_NO_RATE
                                    : (any_next ? ST_OK : ST_NO_AUDIO);
            endcase
            fin_res = '{sample: 8'd0, repeat_n: 17'd0, is_final: 1'b1, status: fin_status,
                        rate: locked_next, loop_seen: loop_next};
            if (push_n == 2'd0) begin
                push0 = fin_res;
            end else begin
                push1 = fin_res;
            end
            push_n   = push_n + 2'd1;
            do_clear = 1'b1;
        end

        if (do_clear) begin
            phase_next  = PH_HEADER;
            pos_next    = '0;
            offset_next = '0;
            kind_next   = '0;
            remain_next = '0;
            index_next  = '0;
            cur_next    = '0;
            ext_next    = '0;
            ch_next     = 9'd1;
            locked_next = '0;
            loop_next   = 1'b0;
            any_next    = 1'b0;
            err_next    = ST_OK;
        end

        c1 = qcnt_reg - {1'b0, pop};
        s0 = pop ? q1_reg : q0_reg;
        s1 = q1_reg;
        q0_next   = (c1 == 2'd0) ? push0 : s0;
        q1_next   = (c1 == 2'd0) ? push1 : ((c1 == 2'd1) ? push0 : s1);
        qcnt_next = c1 + push_n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HEADER;
            seq_reg    <= SQ_IDLE;
            op_reg     <= OP_PCM_RATE;
            pos_reg    <= '0;
            offset_reg <= '0;
            kind_reg   <= '0;
            remain_reg <= '0;
            index_reg  <= '0;
            cur_reg    <= '0;
            ext_reg    <= '0;
            ch_reg     <= 9'd1;
            locked_reg <= '0;
            loop_reg   <= 1'b0;
            any_reg    <= 1'b0;
            err_reg    <= ST_OK;
            lastp_reg  <= 1'b0;
            pass2_reg  <= 1'b0;
            cnt_reg    <= '0;
            qcnt_reg   <= '0;
        end else begin
            phase_reg  <= phase_next;
            seq_reg    <= seq_next;
            op_reg     <= op_next;
            pos_reg    <= pos_next;
            offset_reg <= offset_next;
            kind_reg   <= kind_next;
            remain_reg <= remain_next;
            index_reg  <= index_next;
            cur_reg    <= cur_next;
            ext_reg    <= ext_next;
            ch_reg     <= ch_next;
            locked_reg <= locked_next;
            loop_reg   <= loop_next;
            any_reg    <= any_next;
            err_reg    <= err_next;
            lastp_reg  <= lastp_next;
            pass2_reg  <= pass2_next;
            cnt_reg    <= cnt_next;
            qcnt_reg   <= qcnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        q0_reg  <= q0_next;
        q1_reg  <= q1_next;
        if (scr_we) begin
            scratch[scr_idx] <= s_data_byte;
        end
    end

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        qcnt_reg != 2'd3)
        else $error("result queue overflow");

    a_last_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        acc && s_last_byte && !div_go |=> phase_reg == PH_HEADER && pos_reg == 32'd0)
        else $error("parse state not cleared after last byte");

    a_div_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        seq_reg == SQ_DIV && cnt_reg == 5'd31 && (op_reg != OP_EXT_RATE || pass2_reg)
        |=> seq_reg == SQ_POST)
        else $error("divider did not hand over to post step");

    a_busy_no_take: assert property (@(posedge aclk) disable iff (!aresetn)
        acc && div_go |=> !s_ready && seq_reg == SQ_DIV)
        else $error("byte taken while divider busy");

endmodule

>>> tb/voc_block_stream_decoder_tb.sv
// Testbench for the VOC block stream decoder: byte-level model, directed files, random files.
module voc_block_stream_decoder_tb;
    import vocd_pkg::*;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last_byte;
        logic        chk;
        logic [3:0]  want_status;
    } row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic        s_last_byte;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_sample_value;
    logic [16:0] m_repeat_count;
    logic        m_is_final;
    logic [3:0]  m_status;
    logic [31:0] m_stream_rate;
    logic        m_loop_seen;

    voc_block_stream_decoder u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_data_byte(s_data_byte), .s_last_byte(s_last_byte),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_sample_value(m_sample_value), .m_repeat_count(m_repeat_count),
        .m_is_final(m_is_final), .m_status(m_status),
        .m_stream_rate(m_stream_rate), .m_loop_seen(m_loop_seen)
    );

    // decoder state mirror
    phase_t      ph;
    logic [31:0] fpos;
    logic [31:0] doff;
    logic [7:0]  kind;
    logic [23:0] brem;
    logic [23:0] bidx;
    logic [7:0]  scr [12];
    logic [31:0] cur_rate;
    logic [31:0] ext_rate;
    logic [31:0] ext_ch;
    logic [31:0] lock_r;
    logic        loop_f;
    logic        any_s;
    logic [3:0]  err;

    res_t        exp_q[$];
    res_t        pend[$];
    row_t        dir_q[$];
    logic [7:0]  file_q[$];
    logic [4:0]  want_q[$];
    int          errors;
    int          cycles;
    bit          quiet;
    bit          final_chk;
    logic [3:0]  final_want;

    function automatic void dec_reset();
        ph = PH_HEADER; fpos = 0; doff = 0; kind = 0; brem = 0; bidx = 0;
        for (int i = 0; i < 12; i++) scr[i] = 0;
        cur_rate = 0; ext_rate = 0; ext_ch = 1; lock_r = 0;
        loop_f = 0; any_s = 0; err = ST_OK;
    endfunction

    function automatic void abort_with(logic [3:0] code);
        err = code;
        ph = PH_FAIL;
    endfunction

    function automatic void emit(logic [7:0] smp, logic [16:0] rep, logic fin, logic [3:0] st);
        res_t r;
        r.sample = smp; r.repeat_n = rep; r.is_final = fin; r.status = st;
        r.rate = lock_r; r.loop_seen = loop_f;
        pend.push_back(r);
    endfunction

    function automatic bit take_rate(logic [31:0] rate);
        cur_rate = rate;
        if (lock_r == 0) lock_r = rate;
        if (lock_r != rate) begin
            abort_with(ST_RATE_MISM);
            return 0;
        end
        return 1;
    endfunction

    function automatic void open_block();
        logic [23:0] len;
        len = brem;
        bidx = 0;
        case (kind)
            KIND_PCM: if (len < 2) begin abort_with(ST_BAD_BLOCK); return; end
            KIND_CONT: if (cur_rate == 0) begin abort_with(ST_NO_RATE); return; end
            KIND_SILENCE: if (len < 3) begin abort_with(ST_BAD_BLOCK); return; end
            KIND_LOOP: loop_f = 1;
            KIND_EXT: if (len < 4) begin abort_with(ST_BAD_BLOCK); return; end
            KIND_PCM_NEW: if (len < 12) begin abort_with(ST_BAD_BLOCK); return; end
            default: ;
        endcase
        ph = (len != 0) ? PH_BODY : PH_TYPE;
    endfunction

    function automatic void body(logic [7:0] b);
        logic [31:0] i;
        logic [31:0] rate;
        logic [31:0] ch;
        i = bidx;
        if (i < 12) scr[i] = b;
        case (kind)
            KIND_PCM: begin
                if (i == 1) begin
                    if (b != 0 || ext_ch != 1) abort_with(ST_UNSUPPORTED);
                    else begin
                        rate = (ext_rate != 0) ? ext_rate : RATE_BASE / (32'd256 - scr[0]);
                        if (take_rate(rate)) begin
                            ext_rate = 0;
                            ext_ch = 1;
                        end
                    end
                end else if (i >= 2) begin
                    emit(b, 1, 0, ST_OK);
                    any_s = 1;
                end
            end
            KIND_CONT: begin
                emit(b, 1, 0, ST_OK);
                any_s = 1;
            end
            KIND_SILENCE: begin
                if (i == 2) begin
                    if (b == RATE_BYTE_MAX) abort_with(ST_BAD_BLOCK);
                    else if (take_rate(RATE_BASE / (32'd256 - b))) begin
                        emit(SILENCE_VAL, {scr[1], scr[0]} + 17'd1, 0, ST_OK);
                        any_s = 1;
                    end
                end
            end
            KIND_EXT: begin
                if (i == 2) begin
                    if (b != 0) abort_with(ST_UNSUPPORTED);
                end else if (i == 3) begin
                    ch = b + 32'd1;
                    ext_ch = ch;
                    ext_rate = EXT_BASE / (32'd65536 - {scr[1], scr[0]}) / ch;
                end
            end
            KIND_PCM_NEW: begin
                if (i == 4) begin
                    if (b != 8) abort_with(ST_UNSUPPORTED);
                end else if (i == 5) begin
                    if (b != 1) abort_with(ST_UNSUPPORTED);
                end else if (i == 7) begin
                    if ({b, scr[6]} != 0) abort_with(ST_UNSUPPORTED);
                    else void'(take_rate({scr[3], scr[2], scr[1], scr[0]}));
                end else if (i >= 12) begin
                    emit(b, 1, 0, ST_OK);
                    any_s = 1;
                end
            end
            default: ;
        endcase
        if (ph == PH_BODY) begin
            bidx = bidx + 1;
            brem = brem - 1;
            if (brem == 0) ph = PH_TYPE;
        end
    endfunction

    function automatic void decode_byte(logic [7:0] b, logic last);
        logic [31:0] pos;
        logic [3:0]  st;
        pos = fpos;
        if (fpos != 32'hffff_ffff) fpos = fpos + 1;
        case (ph)
            PH_HEADER: begin
                if (pos < SIG_LEN) begin
                    if (b != sig_byte(pos[4:0])) abort_with(ST_BAD_HEADER);
                end else if (pos == SIG_LEN) begin
                    if (b != SIG_EOF) abort_with(ST_BAD_HEADER);
                end else if (pos == 20) doff = b;
                else if (pos == 21) doff = doff | (b << 8);
                else if (pos >= 25) begin
                    if (doff < HDR_LEN) abort_with(ST_BAD_OFFSET);
                    else ph = (fpos >= doff) ? PH_TYPE : PH_SKIP;
                end
            end
            PH_SKIP: if (fpos >= doff) ph = PH_TYPE;
            PH_TYPE: begin
                if (b == 0) ph = PH_DONE;
                else begin
                    kind = b; brem = 0; bidx = 0; ph = PH_LEN;
                end
            end
            PH_LEN: begin
                brem = brem | (24'(b) << (8 * bidx[1:0]));
                bidx = bidx + 1;
                if (bidx >= 3) open_block();
            end
            PH_BODY: body(b);
            default: ;
        endcase
        if (last) begin
            case (ph)
                PH_FAIL: st = err;
                PH_HEADER: st = ST_BAD_HEADER;
                PH_SKIP: st = ST_BAD_OFFSET;
                PH_LEN, PH_BODY: st = ST_TRUNCATED;
                default: st = (lock_r == 0) ? ST_NO_RATE : (any_s ? ST_OK : ST_NO_AUDIO);
            endcase
            emit(0, 0, 1, st);
            dec_reset();
        end
    endfunction

    // file building
    task automatic put_hdr(int off);
        for (int i = 0; i < 19; i++) file_q.push_back(sig_byte(i[4:0]));
        file_q.push_back(SIG_EOF);
        file_q.push_back(off[7:0]);
        file_q.push_back(off[15:8]);
        repeat (4) file_q.push_back($urandom_range(0, 255));
        for (int i = 26; i < off; i++) file_q.push_back($urandom_range(0, 255));
    endtask

    task automatic put_blk(logic [7:0] k, int len);
        file_q.push_back(k);
        file_q.push_back(len[7:0]);
        file_q.push_back(len[15:8]);
        file_q.push_back(len[23:16]);
    endtask

    task automatic put_rand(int n);
        repeat (n) file_q.push_back($urandom_range(0, 255));
    endtask

    task automatic build_file();
        int nb;
        int len;
        int pick;
        logic [7:0] tc;
        logic [31:0] r9;
        file_q.delete();
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            put_rand($urandom_range(1, 40));
            return;
        end
        put_hdr((pick == 1) ? $urandom_range(0, 40) : (26 + (($urandom_range(0, 3) == 0) ?
                $urandom_range(0, 6) : 0)));
        tc = $urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : 8'd156;
        r9 = $urandom_range(0, 3) == 0 ? $urandom : 32'd10000;
        nb = $urandom_range(1, 4);
        repeat (nb) begin
            len = $urandom_range(0, 7);
            case ($urandom_range(0, 9))
                0, 1: begin
                    len = $urandom_range(0, 8);
                    put_blk(KIND_PCM, len);
                    if (len > 0) file_q.push_back(tc);
                    if (len > 1) file_q.push_back($urandom_range(0, 5) == 0 ? 8'd4 : 8'd0);
                    if (len > 2) put_rand(len - 2);
                end
                2: begin put_blk(KIND_CONT, len); put_rand(len); end
                3: begin
                    len = $urandom_range(2, 4);
                    put_blk(KIND_SILENCE, len);
                    put_rand(2);
                    if (len > 2) file_q.push_back($urandom_range(0, 7) == 0 ? 8'hff : tc);
                    if (len > 3) put_rand(1);
                end
                4: begin put_blk(KIND_LOOP, $urandom_range(0, 2)); put_rand(file_q[$-2]); end
                5: begin
                    len = $urandom_range(3, 5);
                    put_blk(KIND_EXT, len);
                    put_rand(2);
                    if (len > 2) file_q.push_back($urandom_range(0, 4) == 0 ? 8'd1 : 8'd0);
                    if (len > 3) file_q.push_back($urandom_range(0, 3) == 0 ?
                                                  $urandom_range(0, 255) : 8'd0);
                    if (len > 4) put_rand(1);
                end
                6, 7: begin
                    len = $urandom_range(11, 18);
                    put_blk(KIND_PCM_NEW, len);
                    for (int j = 0; j < len; j++) begin
                        if (j < 4) file_q.push_back(r9[8*j +: 8]);
                        else if (j == 4) file_q.push_back($urandom_range(0, 9) == 0 ? 8'd16 : 8'd8);
                        else if (j == 5) file_q.push_back($urandom_range(0, 9) == 0 ? 8'd2 : 8'd1);
                        else if (j == 6 || j == 7)
                            file_q.push_back($urandom_range(0, 11) == 0 ? 8'd1 : 8'd0);
                        else file_q.push_back($urandom_range(0, 255));
                    end
                end
                8: begin put_blk($urandom_range(10, 255), len); put_rand(len); end
                default: begin put_blk(KIND_PCM_NEW, 0); end
            endcase
        end
        if ($urandom_range(0, 3) != 0) file_q.push_back(8'h00);
        if ($urandom_range(0, 4) == 0) put_rand($urandom_range(1, 3));
        if ($urandom_range(0, 5) == 0) void'(file_q.pop_back());
    endtask

    // stimulus helpers
    int idle_run;
    task automatic send(logic [7:0] b, logic last);
        if ($urandom_range(0, 15) == 0 && !quiet) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        s_last_byte <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        decode_byte(b, last);
        if (last) want_q.push_back({final_chk, final_want});
        while (pend.size()) exp_q.push_back(pend.pop_front());
    endtask

    task automatic send_file();
        for (int i = 0; i < file_q.size(); i++)
            send(file_q[i], i == file_q.size() - 1);
    endtask

    // clock, watchdog
    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 1000000) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result sink
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            idle_run <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (exp_q.size() == 0) begin
                    $error("unexpected result sample=%0h", m_sample_value);
                    errors++;
                end else begin
                    res_t e;
                    logic [4:0] w;
                    e = exp_q.pop_front();
                    w = '0;
                    if (e.is_final && want_q.size()) w = want_q.pop_front();
                    if (m_sample_value !== e.sample) begin
                        $error("sample_value exp %0h got %0h", e.sample, m_sample_value); errors++;
                    end
                    if (m_repeat_count !== e.repeat_n) begin
                        $error("repeat_count exp %0d got %0d", e.repeat_n, m_repeat_count); errors++;
                    end
                    if (m_is_final !== e.is_final) begin
                        $error("is_final exp %0d got %0d", e.is_final, m_is_final); errors++;
                    end
                    if (m_status !== e.status) begin
                        $error("status exp %0d got %0d", e.status, m_status); errors++;
                    end
                    if (e.is_final && w[4] && m_status !== w[3:0]) begin
                        $error("status exp %0d got %0d", w[3:0], m_status); errors++;
                    end
                    if (m_stream_rate !== e.rate) begin
                        $error("stream_rate exp %0d got %0d", e.rate, m_stream_rate); errors++;
                    end
                    if (m_loop_seen !== e.loop_seen) begin
                        $error("loop_seen exp %0d got %0d", e.loop_seen, m_loop_seen); errors++;
                    end
                end
            end
            if (quiet) m_ready <= 1'b1;
            else if (idle_run > 0) begin
                m_ready <= 1'b0;
                idle_run <= idle_run - 1;
            end else if ($urandom_range(0, 11) == 0) begin
                m_ready <= 1'b0;
                idle_run <= $urandom_range(0, 13);
            end else m_ready <= 1'b1;
        end
    end

    task automatic add_rows(logic [3:0] want);
        for (int i = 0; i < file_q.size(); i++)
            dir_q.push_back('{file_q[i], i == file_q.size() - 1, i == file_q.size() - 1, want});
    endtask

    initial begin
        int nbytes;
        row_t r;
        errors = 0; cycles = 0; quiet = 0; final_chk = 0; final_want = ST_OK;
        s_valid = 0; s_data_byte = 0; s_last_byte = 0; m_ready = 0;
        aresetn = 0;
        dec_reset();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table: short header, bad offset, good 8-bit PCM with loop and silence
        file_q = '{8'hff};
        add_rows(ST_BAD_HEADER);
        file_q.delete(); put_hdr(3); add_rows(ST_BAD_OFFSET);
        file_q.delete(); put_hdr(26);
        put_blk(KIND_PCM, 4);
        file_q.push_back(8'd156); file_q.push_back(8'd0);
        file_q.push_back(8'h00); file_q.push_back(8'hff);
        put_blk(KIND_SILENCE, 3);
        file_q.push_back(8'hff); file_q.push_back(8'hff); file_q.push_back(8'd156);
        put_blk(KIND_LOOP, 0);
        file_q.push_back(8'h00);
        add_rows(ST_OK);
        foreach (dir_q[i]) begin
            r = dir_q[i];
            final_chk = r.chk;
            final_want = r.want_status;
            send(r.data_byte, r.last_byte);
        end
        s_valid <= 1'b0;
        while (exp_q.size()) @(posedge aclk);
        final_chk = 0;
        repeat (20) @(posedge aclk);

        // random files
        nbytes = 0;
        while (nbytes < 1380) begin
            if (nbytes > 1100) quiet = 1;
            build_file();
            nbytes += file_q.size();
            send_file();
            if ($urandom_range(0, 9) == 0) begin
                s_valid <= 1'b0;
                while (exp_q.size()) @(posedge aclk);
            end
        end
        s_valid <= 1'b0;
        while (exp_q.size()) @(posedge aclk);
        repeat (30) @(posedge aclk);
        if (errors == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end

endmodule
